[rtl/core/icfmt_pkg.sv]
// Package for the integer to ASCII formatter.
// Item types, request codes, controller/datapath command and status bundles,
// and the character tables. Used by every module of the block.
package icfmt_pkg;

    localparam logic [2:0] REQ_SDEC = 3'd0;
    localparam logic [2:0] REQ_UDEC = 3'd1;
    localparam logic [2:0] REQ_HEXL = 3'd2;
    localparam logic [2:0] REQ_HEXU = 3'd3;
    localparam logic [2:0] REQ_PTR  = 3'd4;

    localparam int NUM_NIBBLES = 16;
    localparam int DEC_DIGITS  = 10;
    localparam int CONV_STEPS  = 8;   // four bits per step
    localparam int MAX_CHARS   = 18;

    localparam logic [2:0] PRE_LEN_MINUS = 3'd1;
    localparam logic [2:0] PRE_LEN_HEX   = 3'd2;
    localparam logic [2:0] PRE_LEN_NIL   = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] value;
        logic        with_prefix;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic [4:0] char_count;
    } out_item_t;

    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_MINUS,
        PRE_HEX,
        PRE_NIL
    } pre_kind_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic size;
        logic emit_pre;
        logic emit_dig;
    } cmd_t;

    typedef struct packed {
        logic in_ok;
        logic in_dec;
        logic conv_last;
        logic has_pre;
        logic has_dig;
        logic pre_last;
        logic dig_last;
        logic out_free;
    } status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] code;
        if (nib < 4'd10)
        begin
            code = 8'h30 + {4'h0, nib};
        end
        else if (upper)
        begin
            code = 8'h37 + {4'h0, nib};
        end
        else
        begin
            code = 8'h57 + {4'h0, nib};
        end
        return code;
    endfunction

    function automatic logic [7:0] pre_char(input pre_kind_t kind, input logic [2:0] idx);
        logic [7:0] code;
        code = 8'h3f;
        case (kind)
            PRE_MINUS: code = 8'h2d;
            PRE_HEX:   code = (idx == 3'd0) ? 8'h30 : 8'h78;
            PRE_NIL:
            begin
                case (idx)
                    3'd0:    code = 8'h28;
                    3'd1:    code = 8'h6e;
                    3'd2:    code = 8'h69;
                    3'd3:    code = 8'h6c;
                    default: code = 8'h29;
                endcase
            end
            default:   code = 8'h3f;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/icfmt_dp.sv]
// Datapath of the integer to ASCII formatter: operand and digit registers,
// shift-and-add-3 decimal converter, digit sizing and the output register.
// Depends on icfmt_pkg.
module icfmt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  icfmt_pkg::in_item_t in_item,
    input  icfmt_pkg::cmd_t     cmd,
    output icfmt_pkg::status_t  st,
    output logic                out_valid,
    input  logic                out_stall,
    output icfmt_pkg::out_item_t out_item
);

    logic [63:0]              dig_reg, dig_next;
    logic [31:0]              bin_reg, bin_next;
    logic [2:0]               conv_cnt_reg, conv_cnt_next;
    logic                     upper_reg, upper_next;
    logic                     nil_reg, nil_next;
    icfmt_pkg::pre_kind_t     kind_reg, kind_next;
    logic [2:0]               pre_len_reg, pre_len_next;
    logic [2:0]               pre_idx_reg, pre_idx_next;
    logic [3:0]               idx_reg, idx_next;
    logic [4:0]               total_reg, total_next;
    logic                     out_valid_reg, out_valid_next;
    icfmt_pkg::out_item_t     out_reg, out_next;

    logic [31:0] low;
    logic [31:0] mag;
    logic        neg;
    logic [39:0] bcd_step;
    logic [31:0] bin_step;
    logic [4:0]  ndig;
    logic        pre_last;
    logic        dig_last;

    assign low = in_item.value[31:0];
    assign neg = (in_item.req_type == icfmt_pkg::REQ_SDEC) && low[31];
    // The most negative value negates to itself, which reads correctly as unsigned.
    assign mag = neg ? (32'd0 - low) : low;

    // Four shift-and-add-3 steps per cycle on the ten BCD digits.
    always_comb
    begin
        logic [39:0] b;
        logic [31:0] s;
        b = dig_reg[39:0];
        s = bin_reg;
        for (int k = 0; k < 4; k++)
        begin
            for (int d = 0; d < icfmt_pkg::DEC_DIGITS; d++)
            begin
                if (b[d*4 +: 4] >= 4'd5)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[38:0], s[31]};
            s = {s[30:0], 1'b0};
        end
        bcd_step = b;
        bin_step = s;
    end

    // Number of significant digits, at least one.
    always_comb
    begin
        ndig = 5'd1;
        for (int i = 0; i < icfmt_pkg::NUM_NIBBLES; i++)
        begin
            if (dig_reg[i*4 +: 4] != 4'd0)
            begin
                ndig = 5'(i + 1);
            end
        end
    end

    assign pre_last = (pre_idx_reg == (pre_len_reg - 3'd1));
    assign dig_last = (idx_reg == 4'd0);

    always_comb
    begin
        dig_next      = dig_reg;
        bin_next      = bin_reg;
        conv_cnt_next = conv_cnt_reg;
        upper_next    = upper_reg;
        nil_next      = nil_reg;
        kind_next     = kind_reg;
        pre_len_next  = pre_len_reg;
        pre_idx_next  = pre_idx_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            conv_cnt_next = 3'd0;
            upper_next    = (in_item.req_type == icfmt_pkg::REQ_HEXU);
            nil_next      = 1'b0;
            kind_next     = icfmt_pkg::PRE_NONE;
            pre_len_next  = 3'd0;
            bin_next      = mag;
            case (in_item.req_type)
                icfmt_pkg::REQ_SDEC, icfmt_pkg::REQ_UDEC:
                begin
                    dig_next = 64'd0;
                    if (neg)
                    begin
                        kind_next    = icfmt_pkg::PRE_MINUS;
                        pre_len_next = icfmt_pkg::PRE_LEN_MINUS;
                    end
                end
                icfmt_pkg::REQ_PTR:
                begin
                    dig_next = in_item.value;
                    if (in_item.value == 64'd0)
                    begin
                        nil_next     = 1'b1;
                        kind_next    = icfmt_pkg::PRE_NIL;
                        pre_len_next = icfmt_pkg::PRE_LEN_NIL;
                    end
                    else if (in_item.with_prefix)
                    begin
                        kind_next    = icfmt_pkg::PRE_HEX;
                        pre_len_next = icfmt_pkg::PRE_LEN_HEX;
                    end
                end
                default:
                begin
                    dig_next = {32'd0, low};
                end
            endcase
        end

        if (cmd.conv_step)
        begin
            dig_next      = {24'd0, bcd_step};
            bin_next      = bin_step;
            conv_cnt_next = conv_cnt_reg + 3'd1;
        end

        if (cmd.size)
        begin
            pre_idx_next = 3'd0;
            idx_next     = 4'(ndig - 5'd1);
            total_next   = nil_reg ? {2'b00, pre_len_reg} : ({2'b00, pre_len_reg} + ndig);
        end

        if (cmd.emit_pre)
        begin
            pre_idx_next        = pre_idx_reg + 3'd1;
            out_valid_next      = 1'b1;
            out_next.char_code  = icfmt_pkg::pre_char(kind_reg, pre_idx_reg);
            out_next.last_char  = pre_last && nil_reg;
            out_next.char_count = (pre_last && nil_reg) ? total_reg : 5'd0;
        end

        if (cmd.emit_dig)
        begin
            idx_next            = idx_reg - 4'd1;
            out_valid_next      = 1'b1;
            out_next.char_code  = icfmt_pkg::digit_char(dig_reg[idx_reg*4 +: 4], upper_reg);
            out_next.last_char  = dig_last;
            out_next.char_count = dig_last ? total_reg : 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            conv_cnt_reg  <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            conv_cnt_reg  <= conv_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg     <= dig_next;
        bin_reg     <= bin_next;
        upper_reg   <= upper_next;
        nil_reg     <= nil_next;
        kind_reg    <= kind_next;
        pre_len_reg <= pre_len_next;
        pre_idx_reg <= pre_idx_next;
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        st.in_ok     = (in_item.req_type <= icfmt_pkg::REQ_PTR);
        st.in_dec    = (in_item.req_type == icfmt_pkg::REQ_SDEC) ||
                       (in_item.req_type == icfmt_pkg::REQ_UDEC);
        st.conv_last = (conv_cnt_reg == 3'(icfmt_pkg::CONV_STEPS - 1));
        st.has_pre   = (pre_len_reg != 3'd0);
        st.has_dig   = !nil_reg;
        st.pre_last  = pre_last;
        st.dig_last  = dig_last;
        st.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // A number never needs more characters than the longest pointer text.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.size |=> (total_reg <= 5'(icfmt_pkg::MAX_CHARS)))
        else $error("character count beyond maximum");

    // The final digit is always flagged as the last character with its count.
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_dig && dig_last) |=> (out_reg.last_char && out_reg.char_count == total_reg))
        else $error("last digit not flagged");

    // A stalled character stays in place until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled output item changed");

endmodule

[rtl/core/icfmt_ctrl.sv]
// Controller of the integer to ASCII formatter: sequences load, decimal
// conversion, sizing and character emission. Depends on icfmt_pkg.
module icfmt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  icfmt_pkg::status_t st,
    output icfmt_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIZE,
        S_PRE,
        S_DIG
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                // Items with an undefined type are taken and dropped.
                if (in_valid && st.in_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.in_dec ? S_CONV : S_SIZE;
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (st.conv_last)
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                cmd.size   = 1'b1;
                state_next = st.has_pre ? S_PRE : S_DIG;
            end
            S_PRE:
            begin
                if (st.out_free)
                begin
                    cmd.emit_pre = 1'b1;
                    if (st.pre_last)
                    begin
                        state_next = st.has_dig ? S_DIG : S_IDLE;
                    end
                end
            end
            S_DIG:
            begin
                if (st.out_free)
                begin
                    cmd.emit_dig = 1'b1;
                    if (st.dig_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.conv_step, cmd.size, cmd.emit_pre, cmd.emit_dig}))
        else $error("more than one datapath command");

    // A character is only written when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pre || cmd.emit_dig) |-> st.out_free)
        else $error("emit into a full output register");

    // Conversion always runs its full length before sizing.
    a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIZE && $past(state_reg) == S_CONV) |-> $past(st.conv_last))
        else $error("conversion cut short");

endmodule

[rtl/core/integer_to_ascii_formatter_top.sv]
// Integer to ASCII formatter, one number in, one character out per result item.
// A number is taken only while the block is idle. Hex and pointer types go from
// load straight to sizing, while decimal types first pass through an eight-step
// shift-and-add-3 converter handling four bits a step; then one character
// per cycle follows while the output is not stalled, up to 18 characters per
// number. The last character sits in the output register while the next
// number is already taken. Types 5 to 7 are taken and produce nothing.
// Depends on icfmt_pkg, icfmt_ctrl and icfmt_dp.
module integer_to_ascii_formatter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  icfmt_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output icfmt_pkg::out_item_t out_item
);

    icfmt_pkg::cmd_t    cmd;
    icfmt_pkg::status_t st;

    icfmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    icfmt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
